// ----- hw/rtl/ualu_pkg.sv -----
// ----------------------------------------------------------------------------
// ualu_pkg: shared types and constants of the unsigned ALU
// Word width, opcode and status codes, and the command and response words.
// ----------------------------------------------------------------------------
package ualu_pkg;

	localparam int W     = 64;          // working word width, 8..64
	localparam int H     = W / 2;       // low half for the partial products
	localparam int HI    = W - H;       // high half
	localparam int SHW   = 7;           // shift count field width
	localparam int DATAW = 64;          // port field width

	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_OR  = 4'd1;
	localparam logic [3:0] OP_NOT = 4'd2;
	localparam logic [3:0] OP_NEG = 4'd3;
	localparam logic [3:0] OP_CMP = 4'd4;
	localparam logic [3:0] OP_ADD = 4'd5;
	localparam logic [3:0] OP_SUB = 4'd6;
	localparam logic [3:0] OP_INC = 4'd7;
	localparam logic [3:0] OP_MUL = 4'd8;
	localparam logic [3:0] OP_DIV = 4'd9;
	localparam logic [3:0] OP_MOD = 4'd10;
	localparam logic [3:0] OP_SHL = 4'd11;
	localparam logic [3:0] OP_SHR = 4'd12;
	localparam logic [3:0] OP_SAR = 4'd13;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_CARRY = 3'd1;
	localparam logic [2:0] ST_BORROW = 3'd2;
	localparam logic [2:0] ST_DIV0  = 3'd3;
	localparam logic [2:0] ST_MOD0  = 3'd4;
	localparam logic [2:0] ST_SHIFT = 3'd5;
	localparam logic [2:0] ST_MUL1  = 3'd6;
	localparam logic [2:0] ST_MUL2  = 3'd7;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef struct packed {
		logic [3:0]       mode;
		logic [DATAW-1:0] operand_a;
		logic [DATAW-1:0] operand_b;
		logic [SHW-1:0]   shift_amount;
		logic [DATAW-1:0] fill_in;
		logic [DATAW-1:0] spill_in;
	} cmd_t;

	typedef struct packed {
		logic [DATAW-1:0] result_low;
		logic [DATAW-1:0] result_high;
		logic [1:0]       order;
		logic [2:0]       status;
	} rsp_t;

	// results that ride alongside the divider
	typedef struct packed {
		logic [3:0]   mode;
		logic [W-1:0] rl;
		logic [W-1:0] rh;
		logic [1:0]   ord;
		logic [2:0]   st;
		logic         bzero;
	} side_t;

endpackage

// ----- hw/rtl/ualu_div.sv -----
// ----------------------------------------------------------------------------
// ualu_div: pipelined restoring divider
// One quotient bit per stage, W stages; carries a side word along.
// ----------------------------------------------------------------------------
module ualu_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic [ualu_pkg::W-1:0] dividend,
	input  logic [ualu_pkg::W-1:0] divisor,
	input  ualu_pkg::side_t      side,
	output logic                 vld_o,
	output logic [ualu_pkg::W-1:0] quotient,
	output logic [ualu_pkg::W-1:0] remainder,
	output ualu_pkg::side_t      side_o
);
	import ualu_pkg::*;

	logic         vld_s  [W+1];
	logic [W-1:0] rem_s  [W+1];
	logic [W-1:0] num_s  [W+1];
	logic [W-1:0] d_s    [W+1];
	side_t        side_s [W+1];

	assign vld_s[0]  = vld;
	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign d_s[0]    = divisor;
	assign side_s[0] = side;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0]   trial;
		logic [W:0]   diff;
		logic         take;

		// shift in the next dividend bit and try the subtract
		assign trial = {rem_s[i], num_s[i][W-1]};
		assign diff  = trial - {1'b0, d_s[i]};
		assign take  = (trial >= {1'b0, d_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? diff[W-1:0] : trial[W-1:0];
				num_s[i+1]  <= {num_s[i][W-2:0], take};
				d_s[i+1]    <= d_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_o     = vld_s[W];
	assign quotient  = num_s[W];
	assign remainder = rem_s[W];
	assign side_o    = side_s[W];

endmodule

// ----- hw/rtl/unsigned_alu_64.sv -----
// ----------------------------------------------------------------------------
// unsigned_alu_64: pipelined unsigned ALU
// Logic, add/sub, full multiply, divide/modulus and funnel shifts.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | word
//   --------+-----------------------+----------------------------
//   command | cmd_valid / cmd_ready | cmd  (ualu_pkg::cmd_t)
//   response| rsp_valid / rsp_ready | rsp  (ualu_pkg::rsp_t)
//
// One word enters per cycle unless the response register stalls; every operation
// takes the same path, set by the divider, which resolves one quotient bit
// per stage. Stage 1 does the logic, add, shift and partial products,
// stage 2 sums the product, then W divider stages, then the response register.
// A stalled response register holds the whole pipeline; nothing is dropped
// or repeated. Reset clears only the valid bits.
module unsigned_alu_64 (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  ualu_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ualu_pkg::rsp_t  rsp
);
	import ualu_pkg::*;

	logic en;

	// Advance whenever the response register is empty or being taken.
	assign en        = !rsp_valid || rsp_ready;
	assign cmd_ready = en;

	// ---------------- stage 1 logic ----------------
	logic [W-1:0]   a, b, fill, spill, fill_eff;
	logic [SHW-1:0] s;
	logic [W:0]     sum, dif, incr;
	logic [2*W-1:0] shl_lo, shl_hi, shr_lo, shr_hi;
	logic [W-1:0]   rl_c, rh_c;
	logic [1:0]     ord_c;
	logic [2:0]     st_c;

	assign a     = cmd.operand_a[W-1:0];
	assign b     = cmd.operand_b[W-1:0];
	assign s     = cmd.shift_amount;
	assign fill  = cmd.fill_in[W-1:0];
	assign spill = cmd.spill_in[W-1:0];

	assign fill_eff = (cmd.mode == OP_SAR) ? {W{a[W-1]}} : fill;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign dif  = {1'b0, a} - {1'b0, b};
	assign incr = {1'b0, a} + {{W{1'b0}}, 1'b1};

	// Funnel through a double word; upper half for left, lower half for right.
	assign shl_lo = {a, fill} << s;
	assign shl_hi = {spill, a} << s;
	assign shr_lo = {fill_eff, a} >> s;
	assign shr_hi = {a, spill} >> s;

	always_comb begin
		rl_c  = '0;
		rh_c  = '0;
		ord_c = ORD_LT;
		st_c  = ST_OK;
		case (cmd.mode)
			OP_AND: rl_c = a & b;
			OP_OR:  rl_c = a | b;
			OP_NOT: rl_c = ~a;
			OP_NEG: rl_c = ~a + {{(W-1){1'b0}}, 1'b1};
			OP_CMP: begin
				if (a < b)       ord_c = ORD_LT;
				else if (a > b)  ord_c = ORD_GT;
				else             ord_c = ORD_EQ;
			end
			OP_ADD: begin
				rl_c = sum[W-1:0];
				st_c = sum[W] ? ST_CARRY : ST_OK;
			end
			OP_SUB: begin
				rl_c = dif[W-1:0];
				st_c = dif[W] ? ST_BORROW : ST_OK;
			end
			OP_INC: begin
				rl_c = incr[W-1:0];
				st_c = incr[W] ? ST_CARRY : ST_OK;
			end
			OP_SHL, OP_SHR, OP_SAR: begin
				if (s > SHW'(W - 1)) begin
					st_c = ST_SHIFT;
				end else if (cmd.mode == OP_SHL) begin
					rl_c = shl_lo[2*W-1:W];
					rh_c = shl_hi[2*W-1:W];
				end else begin
					rl_c = shr_lo[W-1:0];
					rh_c = shr_hi[W-1:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------- stage 1 registers ----------------
	logic             vld_s1;
	side_t            side_s1;
	logic [W-1:0]     a_s1, b_s1;
	logic [2*H-1:0]   ll_s1;
	logic [W-1:0]     lh_s1, hl_s1;
	logic [2*HI-1:0]  hh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{mode: cmd.mode, rl: rl_c, rh: rh_c, ord: ord_c, st: st_c,
				bzero: (b == '0)};
			a_s1    <= a;
			b_s1    <= b;
			ll_s1   <= a[H-1:0] * b[H-1:0];
			lh_s1   <= a[H-1:0] * b[W-1:H];
			hl_s1   <= a[W-1:H] * b[H-1:0];
			hh_s1   <= a[W-1:H] * b[W-1:H];
		end
	end

	// ---------------- stage 2: product sum ----------------
	logic [2*W-1:0] prod;
	logic           vld_s2;
	side_t          side_c2;
	side_t          side_s2;
	logic [W-1:0]   a_s2, b_s2;

	assign prod = (2*W)'(ll_s1)
		+ ((2*W)'(lh_s1) << H)
		+ ((2*W)'(hl_s1) << H)
		+ ((2*W)'(hh_s1) << (2*H));

	// Drop the product into the side word for a multiply.
	always_comb begin
		side_c2 = side_s1;
		if (side_s1.mode == OP_MUL) begin
			side_c2.rl = prod[W-1:0];
			side_c2.rh = prod[2*W-1:W];
			side_c2.st = (prod[2*W-1:W] == '0) ? ST_MUL1 : ST_MUL2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
		end
	end

	// ---------------- divider ----------------
	logic         vld_dv;
	logic [W-1:0] quo, rem;
	side_t        side_dv;

	ualu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld       (vld_s2),
		.dividend  (a_s2),
		.divisor   (b_s2),
		.side      (side_s2),
		.vld_o     (vld_dv),
		.quotient  (quo),
		.remainder (rem),
		.side_o    (side_dv)
	);

	// ---------------- response register ----------------
	rsp_t rsp_c;

	always_comb begin
		rsp_c             = '0;
		rsp_c.result_low  = DATAW'(side_dv.rl);
		rsp_c.result_high = DATAW'(side_dv.rh);
		rsp_c.order       = side_dv.ord;
		rsp_c.status      = side_dv.st;
		// drop in the divider results; a zero divisor gives zeros and an error
		if (side_dv.mode == OP_DIV) begin
			if (side_dv.bzero) begin
				rsp_c.status = ST_DIV0;
			end else begin
				rsp_c.result_low  = DATAW'(quo);
				rsp_c.result_high = DATAW'(rem);
			end
		end else if (side_dv.mode == OP_MOD) begin
			if (side_dv.bzero) begin
				rsp_c.status = ST_MOD0;
			end else begin
				rsp_c.result_high = DATAW'(rem);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp <= rsp_c;
		end
	end

endmodule

// ----- tb/tb_unsigned_alu_64.sv -----
// ----------------------------------------------------------------------------
// tb_unsigned_alu_64: self-checking testbench of the pipelined unsigned ALU
// Walks a directed table of edge cases, then random commands under random
// idling on both channels, and checks every response against a predictor.
// ----------------------------------------------------------------------------
module tb_unsigned_alu_64;
	timeunit 1ns;
	timeprecision 1ps;
	import ualu_pkg::*;

	localparam int N_DIRECTED = 24;
	localparam int N_RANDOM   = 1330;
	localparam int N_CALM     = 200;      // final stretch with no idling
	localparam int DRAIN      = 80;       // pipeline is W + 3 deep

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	unsigned_alu_64 uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rsp_t pending_rsp[$];
	int   n_errors = 0;
	int   n_checked = 0;
	bit   calm = 1'b0;

	// Compute the response word for one command.
	function automatic rsp_t alu_predict(cmd_t c);
		rsp_t r;
		logic [127:0] prod;
		logic [63:0]  fill;
		int n;
		r = '0;
		case (c.mode)
			OP_AND: r.result_low = c.operand_a & c.operand_b;
			OP_OR:  r.result_low = c.operand_a | c.operand_b;
			OP_NOT: r.result_low = ~c.operand_a;
			OP_NEG: r.result_low = -c.operand_a;
			OP_CMP: r.order = (c.operand_a < c.operand_b) ? ORD_LT :
					(c.operand_a > c.operand_b) ? ORD_GT : ORD_EQ;
			OP_ADD: begin
				{r.status[0], r.result_low} = {1'b0, c.operand_a} + {1'b0, c.operand_b};
				r.status = r.status[0] ? ST_CARRY : ST_OK;
			end
			OP_SUB: begin
				r.result_low = c.operand_a - c.operand_b;
				r.status = (c.operand_b > c.operand_a) ? ST_BORROW : ST_OK;
			end
			OP_INC: begin
				r.result_low = c.operand_a + 64'd1;
				r.status = (r.result_low == '0) ? ST_CARRY : ST_OK;
			end
			OP_MUL: begin
				prod = {64'd0, c.operand_a} * {64'd0, c.operand_b};
				{r.result_high, r.result_low} = prod;
				r.status = (r.result_high == '0) ? ST_MUL1 : ST_MUL2;
			end
			OP_DIV: begin
				if (c.operand_b == '0) r.status = ST_DIV0;
				else begin
					r.result_low  = c.operand_a / c.operand_b;
					r.result_high = c.operand_a % c.operand_b;
				end
			end
			OP_MOD: begin
				if (c.operand_b == '0) r.status = ST_MOD0;
				else r.result_high = c.operand_a % c.operand_b;
			end
			OP_SHL, OP_SHR, OP_SAR: begin
				if (c.shift_amount > 7'd63) r.status = ST_SHIFT;
				else begin
					n = int'(c.shift_amount);
					fill = c.fill_in;
					if (c.mode == OP_SAR) fill = {64{c.operand_a[63]}};
					// a zero count brings in nothing: the 64-bit shift gives 0
					if (c.mode == OP_SHL) begin
						r.result_low  = (c.operand_a << n) | ((n == 0) ? '0 : fill >> (64 - n));
						r.result_high = (c.spill_in << n) |
							((n == 0) ? '0 : c.operand_a >> (64 - n));
					end else begin
						r.result_low  = (c.operand_a >> n) | ((n == 0) ? '0 : fill << (64 - n));
						r.result_high = (c.spill_in >> n) |
							((n == 0) ? '0 : c.operand_a << (64 - n));
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = 64'd1 << $urandom_range(0, 63);
			3: w = w >> $urandom_range(0, 63);
			default: ;
		endcase
		return w;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.mode = 4'($urandom_range(0, 15));
		c.operand_a = rand_word();
		c.operand_b = rand_word();
		if ((c.mode == OP_DIV || c.mode == OP_MOD) && $urandom_range(0, 3) != 0)
			c.operand_b = c.operand_b >> $urandom_range(0, 63);
		c.shift_amount = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(64, 127))
				: 7'($urandom_range(0, 63));
		c.fill_in = rand_word();
		c.spill_in = rand_word();
		return c;
	endfunction

	// Hand one word to the block, with an optional idle burst first.
	task automatic send_word(cmd_t c);
		if (!calm && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		pending_rsp.push_back(alu_predict(c));
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	// Response side: check each accepted word, stall in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: response with none pending: %h", $time, rsp);
					n_errors++;
				end else begin
					rsp_t exp_r;
					exp_r = pending_rsp.pop_front();
					n_checked++;
					if (rsp.result_low !== exp_r.result_low) begin
						$display("%0t: result_low expected %h actual %h",
							$time, exp_r.result_low, rsp.result_low);
						n_errors++;
					end
					if (rsp.result_high !== exp_r.result_high) begin
						$display("%0t: result_high expected %h actual %h",
							$time, exp_r.result_high, rsp.result_high);
						n_errors++;
					end
					if (rsp.order !== exp_r.order) begin
						$display("%0t: order expected %0d actual %0d",
							$time, exp_r.order, rsp.order);
						n_errors++;
					end
					if (rsp.status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.status, rsp.status);
						n_errors++;
					end
				end
			end
			if (calm) rsp_ready <= 1'b1;
			else if (rsp_ready) rsp_ready <= ($urandom_range(0, 4) != 0);
			else rsp_ready <= ($urandom_range(0, 1) == 0);
		end
	end

	// Directed table; a row whose flag is set also carries a hand-typed answer.
	typedef struct {
		cmd_t c;
		bit   has_exp;
		rsp_t r;
	} row_t;
	row_t dir_rows[N_DIRECTED];

	function automatic row_t mk(logic [3:0] m, logic [63:0] a, logic [63:0] b,
			logic [6:0] s, logic [63:0] f, logic [63:0] sp, bit he,
			logic [63:0] rl, logic [63:0] rh, logic [1:0] o, logic [2:0] st);
		row_t x;
		x.c = '{m, a, b, s, f, sp};
		x.has_exp = he;
		x.r = '{rl, rh, o, st};
		return x;
	endfunction

	initial begin
		int k;
		dir_rows[0]  = mk(OP_AND, '1, '1, 0, 0, 0, 1, '1, 0, ORD_LT, ST_OK);
		dir_rows[1]  = mk(OP_OR, 0, 0, 0, 0, 0, 1, 0, 0, ORD_LT, ST_OK);
		dir_rows[2]  = mk(OP_NOT, 0, 0, 0, 0, 0, 1, '1, 0, ORD_LT, ST_OK);
		dir_rows[3]  = mk(OP_NEG, 0, 0, 0, 0, 0, 1, 0, 0, ORD_LT, ST_OK);
		dir_rows[4]  = mk(OP_CMP, 5, 5, 0, 0, 0, 1, 0, 0, ORD_EQ, ST_OK);
		dir_rows[5]  = mk(OP_CMP, '1, 0, 0, 0, 0, 1, 0, 0, ORD_GT, ST_OK);
		dir_rows[6]  = mk(OP_ADD, '1, 1, 0, 0, 0, 1, 0, 0, ORD_LT, ST_CARRY);
		dir_rows[7]  = mk(OP_SUB, 0, 1, 0, 0, 0, 1, '1, 0, ORD_LT, ST_BORROW);
		dir_rows[8]  = mk(OP_INC, '1, 0, 0, 0, 0, 1, 0, 0, ORD_LT, ST_CARRY);
		dir_rows[9]  = mk(OP_MUL, '1, '1, 0, 0, 0, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE,
				ORD_LT, ST_MUL2);
		dir_rows[10] = mk(OP_MUL, 0, '1, 0, 0, 0, 1, 0, 0, ORD_LT, ST_MUL1);
		// cross partial products whose carry must reach the high word
		dir_rows[11] = mk(OP_MUL, 64'hFFFF_FFFF_0000_0001, 64'h0000_0001_FFFF_FFFF,
				0, 0, 0, 0, 0, 0, 0, 0);
		dir_rows[12] = mk(OP_DIV, '1, 0, 0, 0, 0, 1, 0, 0, ORD_LT, ST_DIV0);
		dir_rows[13] = mk(OP_MOD, '1, 0, 0, 0, 0, 1, 0, 0, ORD_LT, ST_MOD0);
		dir_rows[14] = mk(OP_DIV, '1, 1, 0, 0, 0, 1, '1, 0, ORD_LT, ST_OK);
		dir_rows[15] = mk(OP_MOD, '1, 10, 0, 0, 0, 1, 0, 5, ORD_LT, ST_OK);
		dir_rows[16] = mk(OP_SHL, 64'h1234, 0, 0, '1, 64'h55, 1, 64'h1234, 64'h55,
				ORD_LT, ST_OK);
		dir_rows[17] = mk(OP_SHL, '1, 0, 64, '1, '1, 1, 0, 0, ORD_LT, ST_SHIFT);
		dir_rows[18] = mk(OP_SHR, '1, 0, 127, '1, '1, 1, 0, 0, ORD_LT, ST_SHIFT);
		dir_rows[19] = mk(OP_SHL, 64'h8000_0000_0000_0001, 0, 63, '1, '1, 0, 0, 0, 0, 0);
		dir_rows[20] = mk(OP_SHR, 64'h8000_0000_0000_0001, 0, 63, '1, '1, 0, 0, 0, 0, 0);
		dir_rows[21] = mk(OP_SAR, 64'h8000_0000_0000_0000, 0, 4, 0, 64'hF0, 0, 0, 0, 0, 0);
		dir_rows[22] = mk(OP_SAR, 64'h7000_0000_0000_0000, 0, 1, '1, 0, 0, 0, 0, 0, 0);
		dir_rows[23] = mk(4'd15, '1, '1, 3, '1, '1, 1, 0, 0, ORD_LT, ST_OK);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++) begin
			if (dir_rows[k].has_exp && alu_predict(dir_rows[k].c) != dir_rows[k].r) begin
				$display("%0t: table row %0d expected %h actual %h", $time, k,
					dir_rows[k].r, alu_predict(dir_rows[k].c));
				n_errors++;
			end
			send_word(dir_rows[k].c);
		end

		for (k = 0; k < N_RANDOM; k++) begin
			// hold off once until the pipeline has fully drained
			if (k == N_RANDOM / 2) begin
				cmd_valid <= 1'b0;
				while (pending_rsp.size() != 0) @(posedge clk);
			end
			if (k == N_RANDOM - N_CALM) calm = 1'b1;
			send_word(rand_cmd());
		end
		cmd_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d directed and %0d random commands over all opcodes,",
			N_DIRECTED, N_RANDOM);
		$display("with random idling on both channels; %0d responses checked.", n_checked);
		if (n_errors == 0 && pending_rsp.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end
endmodule
